### hdl/sorted_priority_queue_core_macros.svh
// Assertion macros shared by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Checked only while out of reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/spq_pkg.sv
// Types, constants and codes of the sorted priority queue.
package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_WIDTH = 16;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int OCC_W     = 5;
  localparam int STAT_W    = 2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // controller -> datapath
  typedef struct packed {
    logic load;  // capture the input word
    logic exec;  // apply the held word and fill the output register
  } spq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // output register empty or being drained this cycle
  } spq_stat_t;

endpackage

### hdl/spq_if.sv
// Valid/ready channel interfaces for the input and result words.
interface spq_in_if import spq_pkg::*; ();
  logic valid;
  logic ready;
  logic kind;
  key_t key;

  modport source (output valid, input ready, output kind, output key);
  modport sink   (input valid, output ready, input kind, input key);
endinterface

interface spq_out_if import spq_pkg::*; ();
  logic              valid;
  logic              ready;
  key_t              popped_key;
  logic              popped_valid;
  logic [STAT_W-1:0] status;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, input ready, output popped_key, output popped_valid,
                  output status, output occupancy);
  modport sink   (input valid, output ready, input popped_key, input popped_valid,
                  input status, input occupancy);
endinterface

### hdl/spq_ctrl.sv
// Controller: accepts one word, then runs it once the output register is free.
module spq_ctrl import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  spq_stat_t stat,
  output spq_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/spq_datapath.sv
// Datapath: shift-register sorted key array, entry count and output register.
module spq_datapath import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_kind,
  input  key_t      in_key,
  input  spq_cmd_t  cmd,
  output spq_stat_t stat,
  spq_out_if.source out_ch
);

  logic              kind_r;
  key_t              key_r;
  key_t              keys_r   [DEPTH];
  key_t              keys_nxt [DEPTH];
  cnt_t              count_r, count_nxt;
  logic              out_valid_r;
  key_t              out_key_r;
  logic              out_pvalid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [OCC_W-1:0]  out_occ_r;

  logic [DEPTH-1:0]  stay;
  logic              empty, full;
  logic              do_pop, do_ins;

  assign empty  = (count_r == '0);
  assign full   = (count_r == CNT_W'(DEPTH));
  assign do_pop = cmd.exec && (kind_r == KIND_POP) && !empty;
  assign do_ins = cmd.exec && (kind_r == KIND_INSERT) && !full;

  assign stat.out_free = !out_valid_r || out_ch.ready;

  // Entries that keep their slot on insert; a key equal to the head stays behind it.
  always_comb begin
    stay[0] = (count_r != '0) && (key_r >= keys_r[0]);
    for (int i = 1; i < DEPTH; i++) begin
      stay[i] = (CNT_W'(i) < count_r) && (keys_r[i] < key_r);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      keys_nxt[i] = keys_r[i];
    end
    count_nxt = count_r;
    if (do_pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        keys_nxt[i] = keys_r[i + 1];
      end
      count_nxt = count_r - cnt_t'(1);
    end else if (do_ins) begin
      if (!stay[0]) begin
        keys_nxt[0] = key_r;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (!stay[i]) begin
          keys_nxt[i] = stay[i - 1] ? key_r : keys_r[i - 1];
        end
      end
      count_nxt = count_r + cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      key_r  <= in_key;
    end
    for (int i = 0; i < DEPTH; i++) begin
      keys_r[i] <= keys_nxt[i];
    end
    if (cmd.exec) begin
      out_key_r    <= do_pop ? keys_r[0] : '0;
      out_pvalid_r <= do_pop;
      if (kind_r == KIND_POP) begin
        out_status_r <= empty ? ST_EMPTY : ST_OK;
      end else begin
        out_status_r <= full ? ST_FULL : ST_OK;
      end
      out_occ_r <= OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_key   = out_key_r;
  assign out_ch.popped_valid = out_pvalid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.occupancy    = out_occ_r;

endmodule

### hdl/sorted_priority_queue_core.sv
// Sorted priority queue: one word in, one result word out per insert or pop.
// The accepted word is held in the input register; once the output register is free it is
// applied to the queue and its result word is written to the output register.
// A new word is taken only after the last one has been run; the controller holds a word until
// the output register is free, so a stalled output delays the next word.
// Reset (rst_n low, synchronous): queue empties, output valid and controller clear.
module sorted_priority_queue_core import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

`include "sorted_priority_queue_core_macros.svh"

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spq_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_kind (in_ch.kind),
    .in_key  (in_ch.key),
    .cmd     (cmd),
    .stat    (stat),
    .out_ch  (out_ch)
  );

  `SPQ_ASSERT(a_one_at_a_time, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "word accepted while one in flight")
  `SPQ_ASSERT(a_exec_needs_slot, cmd.exec |-> stat.out_free, "result written over a pending result")
  `SPQ_ASSERT(a_pop_fields, (out_ch.valid && out_ch.status != ST_OK) |-> (!out_ch.popped_valid && out_ch.popped_key == '0), "error result carries a key")
  `SPQ_ASSERT_ALWAYS(a_no_cmd_overlap, !(cmd.load && cmd.exec), "load and execute in the same cycle")

endmodule
